// File: rtl/swerp_pkg.sv
// package for the sliding window event rate peak block
// types and fixed constants; no dependencies
`default_nettype none

package swerp_pkg;

   // request field widths
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int STATUS_W = 10;
   localparam int CFG_W    = 11;
   localparam int COUNT_W  = 32;

   // absolute minute stamp: day*1440 + hour*60 + minute fits in 16 bits
   localparam int ABS_W = 16;

   localparam int MIN_PER_DAY  = 1440;
   localparam int MIN_PER_HOUR = 60;

   localparam int STATUS_ERR_LO = 500;
   localparam int STATUS_ERR_HI = 599;

   localparam logic [CFG_W-1:0]   WINDOW_RESET = CFG_W'(60);
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_DATA_W  = 3 * COUNT_W + DAY_W + HOUR_W + MINUTE_W + 1;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_PLAN,
      ST_SWEEP,
      ST_READ,
      ST_WRITE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/swerp_mod.sv
// restoring remainder unit, one dividend bit per cycle
// standalone; used by sliding_window_event_rate_peak for the ring position wrap
`default_nettype none

module swerp_mod #(
   parameter int NW = 17,
   parameter int DW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               busy,
   output logic [DW-1:0]      remainder
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    num_ff, num_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      trial;

   always_comb begin
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[NW-1]};
      if (start) begin
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         // remainder stays below the divisor, so the low DW bits hold it
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// File: rtl/sliding_window_event_rate_peak.sv
// sliding window event rate peak tracker, top level
// depends on swerp_pkg and swerp_mod
`default_nettype none

// Use: one request per event on req_ (day, hour, minute, status). Each request
// gives one result on rsp_: events in the window, peak window count and its
// time, the server error flag and the running error total.
// A request walks: capture, gap compute, plan, clear of skipped bins (one bin
// per cycle through the single memory port), bin read, bin write. A gap that
// reaches the window clears all w bins and waits on the remainder unit, which
// takes one bit of its 17-bit dividend per cycle.
// Reset, and every csr_ write, starts a clearing pass over the first w bins
// of the memory (w the effective window) with req_tready low.
// The result sits in an output register: a stalled receiver does not stop
// the next request from being accepted and processed up to its write step,
// which then holds until the register is free.
module sliding_window_event_rate_peak
   import swerp_pkg::*;
#(
   parameter int WINDOW_MAX = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // event_day, event_hour, event_minute, status_code, zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // window_count, peak_count, peak_day, peak_hour, peak_minute,
   // server_error, error_total, zero fill
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WW = AW + 1;
   localparam int CW = ((AW > ABS_W) ? AW : ABS_W) + 1;

   state_type state_ff, state_in;

   // configuration and effective window
   logic [CFG_W-1:0] window_ff;
   logic [WW-1:0]    w;

   // captured request
   logic [DAY_W-1:0]    ev_day_ff;
   logic [HOUR_W-1:0]   ev_hour_ff;
   logic [MINUTE_W-1:0] ev_minute_ff;
   logic [STATUS_W-1:0] ev_status_ff;

   // block state
   logic [AW-1:0]       ring_pos_ff;
   logic [DAY_W-1:0]    last_day_ff;
   logic [HOUR_W-1:0]   last_hour_ff;
   logic [MINUTE_W-1:0] last_minute_ff;
   logic                seen_ff;
   logic [COUNT_W-1:0]  sum_ff;
   logic [COUNT_W-1:0]  best_ff;
   logic [DAY_W-1:0]    best_day_ff;
   logic [HOUR_W-1:0]   best_hour_ff;
   logic [MINUTE_W-1:0] best_minute_ff;
   logic [COUNT_W-1:0]  err_cnt_ff;

   // per request working registers
   logic [ABS_W-1:0] gap_ff;
   logic [AW-1:0]    walk_addr_ff;
   logic [WW-1:0]    remain_ff;
   logic [AW-1:0]    newpos_ff;
   logic             use_mod_ff;
   logic             sub_pend_ff;

   // memory
   logic [COUNT_W-1:0] bin_mem [WINDOW_MAX];
   logic [COUNT_W-1:0] mem_rd_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_addr;
   logic [COUNT_W-1:0] mem_wd;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // remainder unit
   logic          mod_start, mod_busy;
   logic [WW-1:0] mod_rem;

   logic accept, out_free, commit;

   // combinational datapath
   logic [ABS_W-1:0]    abs_now, abs_last;
   logic [ABS_W:0]      diff;
   logic [ABS_W-1:0]    gap_calc;
   logic [CW-1:0]       pos_gap;
   logic                gap_big;
   logic [AW-1:0]       near_pos;
   logic                walk_end;
   logic [AW-1:0]       walk_next;
   logic [AW-1:0]       pos_start;
   logic [AW-1:0]       pos_sel;
   logic [COUNT_W-1:0]  bin_inc;
   logic [COUNT_W-1:0]  sum_inc;
   logic                peak_new;
   logic [COUNT_W-1:0]  best_next;
   logic [DAY_W-1:0]    best_day_next;
   logic [HOUR_W-1:0]   best_hour_next;
   logic [MINUTE_W-1:0] best_minute_next;
   logic                ev_err;
   logic [COUNT_W-1:0]  err_cnt_next;

   always_comb begin
      if (window_ff == '0) begin
         w = WW'(1);
      end else if (32'(window_ff) > 32'(WINDOW_MAX)) begin
         w = WW'(WINDOW_MAX);
      end else begin
         w = WW'(window_ff);
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // gap from the previous event in minutes, negative taken as zero
   assign abs_now = ABS_W'(ev_day_ff) * ABS_W'(MIN_PER_DAY)
                  + ABS_W'(ev_hour_ff) * ABS_W'(MIN_PER_HOUR)
                  + ABS_W'(ev_minute_ff);
   assign abs_last = ABS_W'(last_day_ff) * ABS_W'(MIN_PER_DAY)
                   + ABS_W'(last_hour_ff) * ABS_W'(MIN_PER_HOUR)
                   + ABS_W'(last_minute_ff);
   assign diff     = {1'b0, abs_now} - {1'b0, abs_last};
   assign gap_calc = (seen_ff && !diff[ABS_W]) ? diff[ABS_W-1:0] : '0;

   assign pos_gap  = CW'(ring_pos_ff) + CW'(gap_ff);
   assign gap_big  = CW'(gap_ff) >= CW'(w);
   // only used when gap is below the window, so one subtract wraps it
   assign near_pos = (pos_gap >= CW'(w)) ? AW'(pos_gap - CW'(w)) : AW'(pos_gap);

   assign walk_end  = ({1'b0, walk_addr_ff} + WW'(1)) == w;
   assign walk_next = walk_end ? '0 : walk_addr_ff + AW'(1);
   assign pos_start = (({1'b0, ring_pos_ff} + WW'(1)) == w) ? '0
                    : ring_pos_ff + AW'(1);
   assign pos_sel   = use_mod_ff ? mod_rem[AW-1:0] : newpos_ff;

   assign bin_inc = (mem_rd_ff == COUNT_MAX) ? mem_rd_ff : mem_rd_ff + COUNT_W'(1);
   assign sum_inc = (sum_ff == COUNT_MAX) ? sum_ff : sum_ff + COUNT_W'(1);
   assign peak_new = sum_inc > best_ff;
   assign best_next        = peak_new ? sum_inc : best_ff;
   assign best_day_next    = peak_new ? ev_day_ff : best_day_ff;
   assign best_hour_next   = peak_new ? ev_hour_ff : best_hour_ff;
   assign best_minute_next = peak_new ? ev_minute_ff : best_minute_ff;
   assign ev_err = (ev_status_ff >= STATUS_W'(STATUS_ERR_LO))
                && (ev_status_ff <= STATUS_W'(STATUS_ERR_HI));
   assign err_cnt_next = (ev_err && err_cnt_ff != COUNT_MAX)
                       ? err_cnt_ff + COUNT_W'(1) : err_cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (walk_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            if (!gap_big && gap_ff == '0) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (remain_ff == WW'(1)) state_in = ST_READ;
         end
         ST_READ: begin
            if (!mod_busy) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) state_in = ST_CLEAR;
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = walk_addr_ff;
      mem_wd     = '0;
      mod_start  = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            // a window write takes the cycle, the request waits
            req_tready = !csr_we;
         end
         ST_CALC: begin
         end
         ST_PLAN: begin
            mod_start = gap_big;
         end
         ST_SWEEP: begin
            // read-first port: old bin comes back while zero goes in
            mem_we = 1'b1;
            mem_re = 1'b1;
         end
         ST_READ: begin
            mem_addr = pos_sel;
            mem_re   = !mod_busy;
         end
         ST_WRITE: begin
            mem_addr = newpos_ff;
            mem_wd   = bin_inc;
            mem_we   = out_free;
            commit   = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) bin_mem[mem_addr] <= mem_wd;
      if (mem_re) mem_rd_ff <= bin_mem[mem_addr];
   end

   swerp_mod #(
      .NW(CW),
      .DW(WW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (pos_gap),
      .divisor   (w),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         window_ff      <= WINDOW_RESET;
         walk_addr_ff   <= '0;
         remain_ff      <= '0;
         sub_pend_ff    <= 1'b0;
         use_mod_ff     <= 1'b0;
         ring_pos_ff    <= '0;
         sum_ff         <= '0;
         seen_ff        <= 1'b0;
         last_day_ff    <= '0;
         last_hour_ff   <= '0;
         last_minute_ff <= '0;
         best_ff        <= '0;
         best_day_ff    <= '0;
         best_hour_ff   <= '0;
         best_minute_ff <= '0;
         err_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sub_pend_ff <= (state_ff == ST_SWEEP) && !csr_we;

         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // new window: bins, ring position and sum restart
         if (csr_we) begin
            window_ff    <= csr_wdata;
            walk_addr_ff <= '0;
            ring_pos_ff  <= '0;
            sum_ff       <= '0;
         end else begin
            if (sub_pend_ff) begin
               sum_ff <= (sum_ff >= mem_rd_ff) ? sum_ff - mem_rd_ff : '0;
            end

            case (state_ff)
               ST_CLEAR: begin
                  walk_addr_ff <= walk_next;
               end
               ST_PLAN: begin
                  use_mod_ff <= gap_big;
                  if (gap_big) begin
                     walk_addr_ff <= '0;
                     remain_ff    <= w;
                  end else begin
                     walk_addr_ff <= pos_start;
                     remain_ff    <= WW'(gap_ff);
                  end
               end
               ST_SWEEP: begin
                  walk_addr_ff <= walk_next;
                  remain_ff    <= remain_ff - WW'(1);
               end
               ST_WRITE: begin
                  if (commit) begin
                     ring_pos_ff    <= newpos_ff;
                     sum_ff         <= sum_inc;
                     best_ff        <= best_next;
                     best_day_ff    <= best_day_next;
                     best_hour_ff   <= best_hour_next;
                     best_minute_ff <= best_minute_next;
                     err_cnt_ff     <= err_cnt_next;
                     last_day_ff    <= ev_day_ff;
                     last_hour_ff   <= ev_hour_ff;
                     last_minute_ff <= ev_minute_ff;
                     seen_ff        <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ev_day_ff    <= req_tdata[DAY_W-1:0];
         ev_hour_ff   <= req_tdata[DAY_W+HOUR_W-1:DAY_W];
         ev_minute_ff <= req_tdata[DAY_W+HOUR_W+MINUTE_W-1:DAY_W+HOUR_W];
         ev_status_ff <= req_tdata[DAY_W+HOUR_W+MINUTE_W+STATUS_W-1:
                                   DAY_W+HOUR_W+MINUTE_W];
      end
      if (state_ff == ST_CALC) begin
         gap_ff <= gap_calc;
      end
      if (state_ff == ST_PLAN) begin
         newpos_ff <= near_pos;
      end else if (state_ff == ST_READ && !mod_busy) begin
         newpos_ff <= pos_sel;
      end
      if (commit) begin
         rsp_data_ff <= {err_cnt_next, ev_err, best_minute_next, best_hour_next,
                         best_day_next, best_next, sum_inc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_DATA_W){1'b0}}, rsp_data_ff};

`ifndef SYNTHESIS
   // ring position stays inside the window whenever a request can be taken
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ({1'b0, ring_pos_ff} < w))
      else $error("ring position outside window");

   // a bin subtraction only lands while sweeping or reading the target bin
   assert property (@(posedge clock) disable iff (reset)
      sub_pend_ff |-> (state_ff == ST_SWEEP || state_ff == ST_READ))
      else $error("bin subtraction outside sweep");

   // the bin write never happens with the remainder still running
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> !mod_busy)
      else $error("write step with remainder unit busy");

   // a result is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      commit && rsp_valid_ff |-> rsp_tready)
      else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire
